FILE: rtl/core/uletq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART line echo transmit queue package
// Shared request codes, the terminator reset value, the response width and
// the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package uletq_pkg;

   localparam logic [1:0] KIND_RX    = 2'd0;
   localparam logic [1:0] KIND_TXRDY = 2'd1;
   localparam logic [1:0] KIND_HOST  = 2'd2;

   localparam logic [7:0] TERM_RESET = 8'd13;

   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic capture;
      logic line_write;
      logic copy_start;
      logic copy_step;
      logic line_clear;
      logic ring_push;
      logic ring_pop;
      logic irq_clear;
      logic take_rdata;
      logic load_out;
   } uletq_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       is_term;
      logic       line_empty;
      logic       irq_on;
      logic       ring_empty;
      logic       copy_done;
      logic       out_free;
   } uletq_status_type;

endpackage
`default_nettype wire

FILE: rtl/core/uart_line_echo_tx_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A request is not taken until the response of the one before it is loaded;
// a line copy moves one byte a cycle through the line store read port. Reset
// clears pointers, counts and the transmit enable and loads terminator 13; the
// two byte stores are not cleared.
// ----------------------------------------------------------------------------
// UART line echo transmit queue
// Echoes received bytes, collects them into a line, copies finished lines
// into a transmit ring and feeds the transmitter on ready events.
// ----------------------------------------------------------------------------
module uart_line_echo_tx_queue_unit #(
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [7:0]                       csr_wr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // data_byte
   input  wire logic [1:0]                       req_tuser,  // req_type
   input  wire logic                             req_tlast,  // write_last
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // send_valid, send_byte, tx_enable, dropped, queue_level, zero fill
   output logic      [uletq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import uletq_pkg::*;

   uletq_cmd_type    cmd;
   uletq_status_type status;

   uletq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   uletq_dp #(.DEPTH(DEPTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

FILE: rtl/core/uletq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uletq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/uletq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART line echo transmit queue controller
// Takes each request through decode, any copy or dequeue, and the response.
// ----------------------------------------------------------------------------
module uletq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire uletq_pkg::uletq_status_type status,
   output uletq_pkg::uletq_cmd_type        cmd
);

   import uletq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_DEQ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
               ready_in    = 1'b0;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (status.kind)
               KIND_RX: begin
                  if (status.is_term) begin
                     if (!status.line_empty) begin
                        cmd.copy_start = 1'b1;
                        state_in       = ST_COPY;
                     end
                  end else begin
                     cmd.line_write = 1'b1;
                  end
               end
               KIND_TXRDY: begin
                  if (status.irq_on) begin
                     if (status.ring_empty) begin
                        cmd.irq_clear = 1'b1;
                     end else begin
                        cmd.ring_pop = 1'b1;
                        state_in     = ST_DEQ;
                     end
                  end
               end
               KIND_HOST: begin
                  cmd.ring_push = 1'b1;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_COPY: begin
            if (status.copy_done) begin
               cmd.line_clear = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.copy_step = 1'b1;
            end
         end
         ST_DEQ: begin
            cmd.take_rdata = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
               ready_in     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule
`default_nettype wire

FILE: rtl/core/uletq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART line echo transmit queue datapath
// Holds the line store, the transmit ring, their pointers and counts, the
// terminator register and the response register.
// ----------------------------------------------------------------------------
module uletq_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [7:0]                           csr_wr_data,
   input  wire logic [7:0]                           req_tdata,
   input  wire logic [1:0]                           req_tuser,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [uletq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire uletq_pkg::uletq_cmd_type             cmd,
   output uletq_pkg::uletq_status_type               status
);

   import uletq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   logic [1:0]    kind_ff;
   logic [7:0]    data_ff;
   logic          last_ff;
   logic [7:0]    term_ff;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] tx_count_ff, tx_count_in;
   logic [CW-1:0] line_count_ff, line_count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic          irq_ff, irq_in;
   logic          sv_ff, sv_in;
   logic [7:0]    sb_ff, sb_in;
   logic          drop_ff, drop_in;
   logic          out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic          line_full, ring_full;
   logic          line_we, line_re;
   logic [7:0]    line_rdata, ring_rdata;
   logic          push_req, push_do;
   logic [7:0]    push_data;
   logic          out_free;
   logic [CW+6:0] level_ext;

   assign line_full = (line_count_ff == DEPTH_C);
   assign ring_full = (tx_count_ff == DEPTH_C);
   assign line_we   = cmd.line_write && !line_full;
   assign line_re   = cmd.copy_step && (rd_idx_ff != line_count_ff);
   assign push_req  = cmd.ring_push || (cmd.copy_step && pend_ff);
   assign push_do   = push_req && !ring_full;
   assign push_data = cmd.ring_push ? data_ff : line_rdata;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign level_ext = {7'd0, tx_count_ff};

   uletq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_count_ff[IW-1:0]),
      .wr_data (data_ff),
      .rd_en   (line_re),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (line_rdata)
   );

   uletq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (push_do),
      .wr_addr (tail_ff),
      .wr_data (push_data),
      .rd_en   (cmd.ring_pop),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      tx_count_in   = tx_count_ff;
      line_count_in = line_count_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      irq_in        = irq_ff;
      sv_in         = sv_ff;
      sb_in         = sb_ff;
      drop_in       = drop_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;

      if (cmd.capture) begin
         sv_in   = 1'b0;
         sb_in   = 8'd0;
         drop_in = 1'b0;
      end
      if (cmd.line_write) begin
         sv_in = 1'b1;
         sb_in = data_ff;
         if (line_full) begin
            drop_in = 1'b1;
         end else begin
            line_count_in = line_count_ff + 1'b1;
         end
      end
      if (cmd.copy_start) begin
         rd_idx_in = '0;
         pend_in   = 1'b0;
         irq_in    = 1'b1;
      end
      if (cmd.copy_step) begin
         pend_in = line_re;
         if (line_re) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
      if (cmd.line_clear) begin
         line_count_in = '0;
      end
      if (push_req) begin
         if (ring_full) begin
            drop_in = 1'b1;
         end else begin
            tail_in     = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
            tx_count_in = tx_count_ff + 1'b1;
         end
      end
      if (cmd.ring_push && last_ff) begin
         irq_in = 1'b1;
      end
      if (cmd.ring_pop) begin
         head_in     = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         tx_count_in = tx_count_ff - 1'b1;
      end
      if (cmd.irq_clear) begin
         irq_in = 1'b0;
      end
      if (cmd.take_rdata) begin
         sv_in = 1'b1;
         sb_in = ring_rdata;
      end
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = {6'd0, level_ext[6:0], drop_ff, irq_ff, sb_ff, sv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff       <= TERM_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         tx_count_ff   <= '0;
         line_count_ff <= '0;
         rd_idx_ff     <= '0;
         pend_ff       <= 1'b0;
         irq_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            term_ff <= csr_wr_data;
         end
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         tx_count_ff   <= tx_count_in;
         line_count_ff <= line_count_in;
         rd_idx_ff     <= rd_idx_in;
         pend_ff       <= pend_in;
         irq_ff        <= irq_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      sv_ff       <= sv_in;
      sb_ff       <= sb_in;
      drop_ff     <= drop_in;
      out_data_ff <= out_data_in;
   end

   always_comb begin
      status.kind       = kind_ff;
      status.is_term    = (data_ff == term_ff);
      status.line_empty = (line_count_ff == '0);
      status.irq_on     = irq_ff;
      status.ring_empty = (tx_count_ff == '0);
      status.copy_done  = !pend_ff && (rd_idx_ff == line_count_ff);
      status.out_free   = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/uletq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART line echo transmit queue checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module uletq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No byte is shown unless a byte is sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0)
      else $error("send byte nonzero without send valid");

   // A request in work blocks the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in work");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind uart_line_echo_tx_queue_unit uletq_checker u_uletq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UART line echo transmit queue
// Streams received bytes, ready events, host writes and unused codes into the
// unit under several terminator settings, predicts every response in a local
// model of the line store and transmit ring, and checks each response field.
// ----------------------------------------------------------------------------
module tb_top;
   import uletq_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RING_DEPTH = 64;
   localparam int HALF_PERIOD = 6;
   localparam int RUN_LIMIT_NS = 5_000_000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } uart_request_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       tx_enable;
      logic       dropped;
      logic [6:0] queue_level;
   } echo_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [7:0]            csr_wr_data = 8'd0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;
   logic [1:0]            req_tuser = 2'd0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   uart_request_type request_backlog[$];
   echo_result_type  echo_expect[$];
   int            items_queued = 0;
   int            items_taken = 0;
   int            responses_seen = 0;
   int            mismatches = 0;
   logic          req_took = 1'b0;
   logic          steady = 1'b0;
   logic [7:0]    phase_term = TERM_RESET;

   logic [7:0]    ring_mem [RING_DEPTH];
   logic [5:0]    ring_head;
   logic [5:0]    ring_tail;
   logic [6:0]    ring_count;
   logic [7:0]    line_mem [RING_DEPTH];
   logic [6:0]    line_len;
   logic          irq_on;
   logic [7:0]    term_reg;

   uart_line_echo_tx_queue_unit #(.DEPTH(RING_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic ring_append(input logic [7:0] b, output logic ok);
      if (ring_count >= RING_DEPTH) begin
         ok = 1'b0;
      end else begin
         ring_mem[ring_tail] = b;
         ring_tail = ring_tail + 6'd1;
         ring_count = ring_count + 7'd1;
         ok = 1'b1;
      end
   endtask

   task automatic predict_echo_queue(input uart_request_type r, output echo_result_type res);
      logic ok;
      res = '0;
      case (r.kind)
         KIND_RX: begin
            if (r.data == term_reg) begin
               if (line_len != 0) begin
                  for (int i = 0; i < line_len; i++) begin
                     ring_append(line_mem[6'(i)], ok);
                     if (!ok) res.dropped = 1'b1;
                  end
                  irq_on = 1'b1;
               end
               line_len = 7'd0;
            end else begin
               if (line_len < RING_DEPTH) begin
                  line_mem[line_len[5:0]] = r.data;
                  line_len = line_len + 7'd1;
               end else begin
                  res.dropped = 1'b1;
               end
               res.send_valid = 1'b1;
               res.send_byte = r.data;
            end
         end
         KIND_TXRDY: begin
            if (irq_on) begin
               if (ring_count != 0) begin
                  res.send_valid = 1'b1;
                  res.send_byte = ring_mem[ring_head];
                  ring_head = ring_head + 6'd1;
                  ring_count = ring_count - 7'd1;
               end else begin
                  irq_on = 1'b0;
               end
            end
         end
         KIND_HOST: begin
            ring_append(r.data, ok);
            if (!ok) res.dropped = 1'b1;
            if (r.last) irq_on = 1'b1;
         end
         default: ;
      endcase
      res.tx_enable = irq_on;
      res.queue_level = ring_count;
   endtask

   // Responses are checked before the request taken at the same edge is
   // predicted; a response never belongs to a request of the same edge.
   always @(posedge clock) begin
      echo_result_type  got;
      echo_result_type  want;
      uart_request_type r;
      if (reset) begin
         ring_head = 6'd0;
         ring_tail = 6'd0;
         ring_count = 7'd0;
         line_len = 7'd0;
         irq_on = 1'b0;
         term_reg = TERM_RESET;
         req_took = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.send_valid = rsp_tdata[0];
            got.send_byte = rsp_tdata[8:1];
            got.tx_enable = rsp_tdata[9];
            got.dropped = rsp_tdata[10];
            got.queue_level = rsp_tdata[17:11];
            if (echo_expect.size() == 0) begin
               report_mismatch($sformatf("response %0d with none expected: %h",
                                         responses_seen, rsp_tdata));
            end else begin
               want = echo_expect.pop_front();
               if (got.send_valid !== want.send_valid)
                  report_mismatch($sformatf("response %0d send_valid %b, expected %b",
                                            responses_seen, got.send_valid, want.send_valid));
               if (got.send_byte !== want.send_byte)
                  report_mismatch($sformatf("response %0d send_byte %h, expected %h",
                                            responses_seen, got.send_byte, want.send_byte));
               if (got.tx_enable !== want.tx_enable)
                  report_mismatch($sformatf("response %0d tx_enable %b, expected %b",
                                            responses_seen, got.tx_enable, want.tx_enable));
               if (got.dropped !== want.dropped)
                  report_mismatch($sformatf("response %0d dropped %b, expected %b",
                                            responses_seen, got.dropped, want.dropped));
               if (got.queue_level !== want.queue_level)
                  report_mismatch($sformatf("response %0d queue_level %0d, expected %0d",
                                            responses_seen, got.queue_level,
                                            want.queue_level));
               if (rsp_tdata[RSP_DATA_W-1:18] !== '0)
                  report_mismatch($sformatf("response %0d fill bits not zero: %h",
                                            responses_seen, rsp_tdata));
            end
            responses_seen++;
         end
         if (csr_wr_en) term_reg = csr_wr_data;
         req_took = req_tvalid && req_tready;
         if (req_took) begin
            r.kind = req_tuser;
            r.data = req_tdata;
            r.last = req_tlast;
            predict_echo_queue(r, want);
            echo_expect.push_back(want);
            items_taken++;
         end
      end
   end

   always @(negedge clock) begin
      uart_request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_took) begin
            req_tvalid <= 1'b1;
         end else if (request_backlog.size() != 0 &&
                      (steady || $urandom_range(0, 99) >= 33)) begin
            r = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= r.kind;
            req_tdata <= r.data;
            req_tlast <= r.last;
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   task automatic add_item(input logic [1:0] kind, input logic [7:0] data, input logic last);
      uart_request_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      request_backlog.push_back(r);
      items_queued++;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      if (v == phase_term) v = v ^ 8'h01;
      return v;
   endfunction

   task automatic add_line(input int len);
      for (int i = 0; i < len; i++)
         add_item(KIND_RX, plain_byte(), 1'($urandom_range(0, 1)));
      add_item(KIND_RX, phase_term, 1'($urandom_range(0, 1)));
   endtask

   task automatic add_host_burst(input int len);
      for (int i = 0; i < len; i++)
         add_item(KIND_HOST, 8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic add_drain(input int len);
      for (int i = 0; i < len; i++)
         add_item(KIND_TXRDY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic add_overflow_run();
      add_line(66);
      add_host_burst(3);
      add_line(5);
      add_drain(70);
   endtask

   task automatic add_random_mix(input int target);
      int start;
      int pick;
      start = items_queued;
      while (items_queued - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_line(($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 12));
         end else if (pick < 55) begin
            add_host_burst(($urandom_range(0, 19) == 0) ? $urandom_range(60, 68)
                                                         : $urandom_range(1, 8));
         end else if (pick < 80) begin
            add_drain(($urandom_range(0, 19) == 0) ? $urandom_range(66, 70)
                                                    : $urandom_range(1, 16));
         end else if (pick < 82) begin
            add_overflow_run();
         end else begin
            repeat ($urandom_range(1, 3))
               add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_taken != items_queued || echo_expect.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_terminator(input logic [7:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phase_term = v;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_item(KIND_TXRDY, 8'hFF, 1'b1);
      add_item(KIND_RX, TERM_RESET, 1'b0);
      add_item(KIND_UNUSED, 8'hA5, 1'b1);
      add_item(KIND_RX, 8'h00, 1'b0);
      add_item(KIND_RX, 8'hFF, 1'b1);
      add_item(KIND_RX, 8'h5A, 1'b0);
      add_item(KIND_RX, TERM_RESET, 1'b0);
      add_drain(5);
      add_item(KIND_HOST, 8'hFF, 1'b0);
      add_item(KIND_HOST, 8'h00, 1'b1);
      add_item(KIND_RX, TERM_RESET, 1'b1);
      add_drain(3);
      add_item(KIND_UNUSED, 8'h00, 1'b0);
      add_overflow_run();
      add_random_mix(40);
      wait_drained();

      write_terminator(8'h00);
      steady = 1'b1;
      add_random_mix(70);
      wait_drained();
      steady = 1'b0;

      write_terminator(8'hFF);
      add_random_mix(70);
      wait_drained();

      write_terminator(8'($urandom_range(1, 254)));
      add_random_mix(60);
      wait_drained();

      write_terminator(TERM_RESET);
      add_random_mix(40);
      wait_drained();
      repeat (12) @(negedge clock);

      if (echo_expect.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", echo_expect.size()));
      if (mismatches == 0) begin
         $display("** uart_line_echo_tx_queue_unit: PASSED **");
      end else begin
         $display("** uart_line_echo_tx_queue_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("ERROR: run did not finish in time");
      $display("** uart_line_echo_tx_queue_unit: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/uletq_pkg.sv
rtl/core/uletq_ram.sv
rtl/core/uletq_ctrl.sv
rtl/core/uletq_dp.sv
rtl/core/uart_line_echo_tx_queue_unit.sv
rtl/core/uletq_checker.sv
bench/tb_top.sv
